// ===== rtl/aml_s5_package_scanner_core_assert.svh =====
// ---------------------------------------------------------------------------
// aml_s5_package_scanner_core_assert.svh
// Assertion macros shared by the scanner checker.
// ---------------------------------------------------------------------------
`ifndef AML_S5_PACKAGE_SCANNER_CORE_ASSERT_SVH
`define AML_S5_PACKAGE_SCANNER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define AML_S5_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define AML_S5_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/aml_s5_pkg.sv =====
// ---------------------------------------------------------------------------
// aml_s5_pkg
// Types, opcodes and element decode shared by the _S5_ package scanner.
// ---------------------------------------------------------------------------
package aml_s5_pkg;

    // AML bytes
    localparam logic [7:0]  PKG_OP    = 8'h12;
    localparam logic [7:0]  CHAR_US   = 8'h5F;
    localparam logic [23:0] WINDOW_S5 = 24'h5F5335;   // "_S5" newest byte low

    // element opcodes
    localparam logic [7:0] OP_ZERO = 8'h00;
    localparam logic [7:0] OP_ONE  = 8'h01;
    localparam logic [7:0] OP_BYTE = 8'h0A;
    localparam logic [7:0] OP_WORD = 8'h0B;
    localparam logic [7:0] OP_ONES = 8'hFF;

    // parse phases, one-hot
    typedef enum logic [13:0] {
        PH_SEARCH = 14'h0001,
        PH_OPCODE = 14'h0002,
        PH_LEAD   = 14'h0004,
        PH_EXTRA  = 14'h0008,
        PH_COUNT  = 14'h0010,
        PH_A_OP   = 14'h0020,
        PH_A_BYTE = 14'h0040,
        PH_A_WLO  = 14'h0080,
        PH_A_WHI  = 14'h0100,
        PH_B_OP   = 14'h0200,
        PH_B_BYTE = 14'h0400,
        PH_B_WLO  = 14'h0800,
        PH_B_WHI  = 14'h1000,
        PH_DONE   = 14'h2000
    } phase_t;

    // data bytes that follow an element opcode
    typedef enum logic [1:0] {
        LEN_NONE = 2'd0,
        LEN_BYTE = 2'd1,
        LEN_WORD = 2'd2
    } elem_len_t;

    // one input word
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } in_word_t;

    // one result word
    typedef struct packed {
        logic        found;
        logic [15:0] sleep_a;
        logic [15:0] sleep_b;
    } result_t;

    // immediate value of an element opcode
    function automatic logic [15:0] op_value(input logic [7:0] op);
        logic [15:0] v;
        unique case (op)
            OP_ONE:  v = 16'h0001;
            OP_ONES: v = 16'hFFFF;
            default: v = 16'h0000;
        endcase
        return v;
    endfunction

    // trailing data length of an element opcode
    function automatic elem_len_t op_len(input logic [7:0] op);
        elem_len_t l;
        unique case (op)
            OP_BYTE: l = LEN_BYTE;
            OP_WORD: l = LEN_WORD;
            default: l = LEN_NONE;
        endcase
        return l;
    endfunction

endpackage

// ===== rtl/aml_s5_in_stage.sv =====
// ---------------------------------------------------------------------------
// aml_s5_in_stage
// Input register: holds one byte word until the parser consumes it.
// ---------------------------------------------------------------------------
module aml_s5_in_stage
    import aml_s5_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_word_t in_word,
    input  logic     take,        // parser consumes the held word
    output logic     held_valid,
    output in_word_t held_word
);

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;

    // free when empty or when the held word leaves this cycle
    assign in_ready   = !valid_reg || take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= in_word;
        end
    end

    assign held_valid = valid_reg;
    assign held_word  = word_reg;

endmodule

// ===== rtl/aml_s5_parser.sv =====
// ---------------------------------------------------------------------------
// aml_s5_parser
// Byte-wise _S5_ search and package element decode, one byte per cycle while fire is high.
// ---------------------------------------------------------------------------
module aml_s5_parser
    import aml_s5_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     fire,        // consume word this cycle
    input  in_word_t word,
    output result_t  result       // outcome if word is the last one
);

    phase_t      phase_reg,  phase_next;
    logic [23:0] recent_reg, recent_next;
    logic [1:0]  skip_reg,   skip_next;
    logic [15:0] first_reg,  first_next;
    logic [15:0] second_reg, second_next;
    logic        done_reg,   done_next;

    // next state for the current byte
    always_comb
    begin
        phase_next  = phase_reg;
        skip_next   = skip_reg;
        first_next  = first_reg;
        second_next = second_reg;
        done_next   = done_reg;
        recent_next = {recent_reg[15:0], word.data};

        unique case (phase_reg)
            PH_SEARCH:
            begin
                if (recent_reg == WINDOW_S5 && word.data == CHAR_US)
                begin
                    phase_next = PH_OPCODE;
                end
            end
            PH_OPCODE:
            begin
                phase_next = (word.data == PKG_OP && !word.last) ? PH_LEAD : PH_SEARCH;
            end
            PH_LEAD:
            begin
                // lead byte bits 7:6 give the extra length bytes
                skip_next  = word.data[7:6];
                phase_next = (word.data[7:6] != 2'd0) ? PH_EXTRA : PH_COUNT;
            end
            PH_EXTRA:
            begin
                skip_next = skip_reg - 2'd1;
                if (skip_reg == 2'd1)
                begin
                    phase_next = PH_COUNT;
                end
            end
            PH_COUNT:
            begin
                phase_next = PH_A_OP;
            end
            PH_A_OP:
            begin
                first_next = op_value(word.data);
                unique case (op_len(word.data))
                    LEN_BYTE: phase_next = PH_A_BYTE;
                    LEN_WORD: phase_next = PH_A_WLO;
                    default:  phase_next = PH_B_OP;
                endcase
            end
            PH_A_BYTE:
            begin
                first_next = {8'd0, word.data};
                phase_next = PH_B_OP;
            end
            PH_A_WLO:
            begin
                first_next = {8'd0, word.data};
                phase_next = PH_A_WHI;
            end
            PH_A_WHI:
            begin
                first_next = {word.data, first_reg[7:0]};
                phase_next = PH_B_OP;
            end
            PH_B_OP:
            begin
                second_next = op_value(word.data);
                unique case (op_len(word.data))
                    LEN_BYTE: phase_next = PH_B_BYTE;
                    LEN_WORD: phase_next = PH_B_WLO;
                    default:
                    begin
                        phase_next = PH_DONE;
                        done_next  = 1'b1;
                    end
                endcase
            end
            PH_B_BYTE:
            begin
                second_next = {8'd0, word.data};
                phase_next  = PH_DONE;
                done_next   = 1'b1;
            end
            PH_B_WLO:
            begin
                second_next = {8'd0, word.data};
                phase_next  = PH_B_WHI;
            end
            PH_B_WHI:
            begin
                second_next = {word.data, second_reg[7:0]};
                phase_next  = PH_DONE;
                done_next   = 1'b1;
            end
            PH_DONE:
            begin
                // later bytes ignored until the last one
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // outcome as seen after this byte
    assign result.found   = done_next;
    assign result.sleep_a = done_next ? first_next  : 16'd0;
    assign result.sleep_b = done_next ? second_next : 16'd0;

    // state update; the last byte returns everything to reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SEARCH;
            recent_reg <= 24'd0;
            skip_reg   <= 2'd0;
            first_reg  <= 16'd0;
            second_reg <= 16'd0;
            done_reg   <= 1'b0;
        end
        else if (fire)
        begin
            if (word.last)
            begin
                phase_reg  <= PH_SEARCH;
                recent_reg <= 24'd0;
                skip_reg   <= 2'd0;
                first_reg  <= 16'd0;
                second_reg <= 16'd0;
                done_reg   <= 1'b0;
            end
            else
            begin
                phase_reg  <= phase_next;
                recent_reg <= recent_next;
                skip_reg   <= skip_next;
                first_reg  <= first_next;
                second_reg <= second_next;
                done_reg   <= done_next;
            end
        end
    end

endmodule

// ===== rtl/aml_s5_out_stage.sv =====
// ---------------------------------------------------------------------------
// aml_s5_out_stage
// Result register: holds one result word until the receiver takes it.
// ---------------------------------------------------------------------------
module aml_s5_out_stage
    import aml_s5_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,         // new result this cycle
    input  result_t load_word,
    output logic    free,         // a result can be loaded this cycle
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_word
);

    logic    valid_reg;
    logic    valid_next;
    result_t word_reg;

    assign free = !valid_reg || out_ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= load_word;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// ===== rtl/aml_s5_package_scanner_core.sv =====
// ---------------------------------------------------------------------------
// aml_s5_package_scanner_core
// Scans one ACPI table body for the _S5_ package and reports its two values.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready, data_byte, last_byte) carries one
//   body byte per word; last_byte marks the final byte of a table.
//   Output channel (out_valid / out_ready, found, sleep_type_a,
//   sleep_type_b) carries one word per table, sent after its last byte.
//   Throughput is one byte per cycle unless a last byte waits for the result
//   register; the parser state machine handles each byte in a single step
//   between the input and result registers, and out_valid rises when the result is registered.
//   Only a last byte needs room in the result register: while the receiver
//   stalls, non-last bytes keep flowing, and a last byte waits in the
//   input register until the pending result is taken.
//   The result reflects the first _S5_ package of the table; sleep types
//   read 0 when found is 0. After the last byte the parser returns to its
//   reset state, ready for the next table.
//   Reset (rst_n low) empties both registers and clears the parser.
// ---------------------------------------------------------------------------
module aml_s5_package_scanner_core
    import aml_s5_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        found,
    output logic [15:0] sleep_type_a,
    output logic [15:0] sleep_type_b
);

    in_word_t in_word;
    in_word_t held_word;
    logic     held_valid;
    logic     fire;
    logic     out_free;
    result_t  step_result;
    result_t  out_word;

    assign in_word.data = data_byte;
    assign in_word.last = last_byte;

    // a last byte needs a free result slot
    assign fire = held_valid && (!held_word.last || out_free);

    aml_s5_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_word    (in_word),
        .take       (fire),
        .held_valid (held_valid),
        .held_word  (held_word)
    );

    aml_s5_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .word   (held_word),
        .result (step_result)
    );

    aml_s5_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire && held_word.last),
        .load_word (step_result),
        .free      (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    assign found        = out_word.found;
    assign sleep_type_a = out_word.sleep_a;
    assign sleep_type_b = out_word.sleep_b;

endmodule

// ===== rtl/aml_s5_checker.sv =====
// ---------------------------------------------------------------------------
// aml_s5_checker
// Port-level checks for the scanner, bound to the top level.
// ---------------------------------------------------------------------------
`include "aml_s5_package_scanner_core_assert.svh"

module aml_s5_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  data_byte,
    input logic        last_byte,
    input logic        out_valid,
    input logic        out_ready,
    input logic        found,
    input logic [15:0] sleep_type_a,
    input logic [15:0] sleep_type_b
);

    // no package means both sleep types read zero
    `AML_S5_ASSERT_NOW(a_zero_when_missing, out_valid && !found, sleep_type_a == 16'd0 && sleep_type_b == 16'd0, "sleep types nonzero without found")

    // with the result register empty, input is never held off
    `AML_S5_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty result register")

    // a stalled result word holds
    `AML_S5_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(found) && $stable(sleep_type_a) && $stable(sleep_type_b), "stalled result word changed")

    // a non-last byte never produces a result
    `AML_S5_ASSERT_NEXT(a_no_result_mid_table, in_valid && in_ready && !last_byte, ##1 !$rose(out_valid), "result raised by a non-last byte")

endmodule

bind aml_s5_package_scanner_core aml_s5_checker u_aml_s5_checker (.*);

// ===== tb/tb_aml_s5_package_scanner_core.sv =====
// ---------------------------------------------------------------------------
// tb_aml_s5_package_scanner_core
// Streams ACPI table bodies into the _S5_ scanner and checks every result
// word against a cycle-free parser kept in the scoreboard. A few directed
// tables come first, then random tables, mostly well-formed packages with
// random contents plus noise and cut-off tables. Both sides idle at random.
// ---------------------------------------------------------------------------
import aml_s5_pkg::*;

// Parser shadow plus the queue of sleep-type results still owed by the block
class s5_result_tracker;
    phase_t      phase     = PH_SEARCH;
    logic [23:0] window    = '0;
    logic [1:0]  skip_left = '0;
    logic [15:0] value_a   = '0;
    logic [15:0] value_b   = '0;
    bit          pkg_done  = 1'b0;
    result_t     sleep_q[$];
    int          errors    = 0;

    function void clear_parse();
        phase     = PH_SEARCH;
        window    = '0;
        skip_left = '0;
        value_a   = '0;
        value_b   = '0;
        pkg_done  = 1'b0;
    endfunction

    // element opcode: immediate value, and how many data bytes follow
    function elem_len_t elem_head(input logic [7:0] op, output logic [15:0] val);
        val       = 16'h0000;
        elem_head = LEN_NONE;
        case (op)
            OP_ONE:  val = 16'h0001;
            OP_ONES: val = 16'hFFFF;
            OP_BYTE: elem_head = LEN_BYTE;
            OP_WORD: elem_head = LEN_WORD;
            default: ;
        endcase
    endfunction

    // advance the parser by one accepted word
    function void note_byte(input logic [7:0] b, input logic last);
        elem_len_t len;
        result_t   r;
        case (phase)
            PH_SEARCH:
                if (window == WINDOW_S5 && b == CHAR_US)
                    phase = PH_OPCODE;
            PH_OPCODE:
                phase = (b == PKG_OP && !last) ? PH_LEAD : PH_SEARCH;
            PH_LEAD:
            begin
                skip_left = b[7:6];
                phase = (skip_left != 2'd0) ? PH_EXTRA : PH_COUNT;
            end
            PH_EXTRA:
            begin
                skip_left = skip_left - 2'd1;
                if (skip_left == 2'd0)
                    phase = PH_COUNT;
            end
            PH_COUNT:
                phase = PH_A_OP;
            PH_A_OP:
            begin
                len = elem_head(b, value_a);
                case (len)
                    LEN_NONE: phase = PH_B_OP;
                    LEN_BYTE: phase = PH_A_BYTE;
                    default:  phase = PH_A_WLO;
                endcase
            end
            PH_A_BYTE:
            begin
                value_a = {8'h00, b};
                phase   = PH_B_OP;
            end
            PH_A_WLO:
            begin
                value_a = {8'h00, b};
                phase   = PH_A_WHI;
            end
            PH_A_WHI:
            begin
                value_a[15:8] = b;
                phase         = PH_B_OP;
            end
            PH_B_OP:
            begin
                len = elem_head(b, value_b);
                case (len)
                    LEN_NONE:
                    begin
                        phase    = PH_DONE;
                        pkg_done = 1'b1;
                    end
                    LEN_BYTE: phase = PH_B_BYTE;
                    default:  phase = PH_B_WLO;
                endcase
            end
            PH_B_BYTE:
            begin
                value_b  = {8'h00, b};
                phase    = PH_DONE;
                pkg_done = 1'b1;
            end
            PH_B_WLO:
            begin
                value_b = {8'h00, b};
                phase   = PH_B_WHI;
            end
            PH_B_WHI:
            begin
                value_b[15:8] = b;
                phase         = PH_DONE;
                pkg_done      = 1'b1;
            end
            default: ;
        endcase
        window = {window[15:0], b};

        // last byte of the table: one result, then a clean parser
        if (last)
        begin
            r.found   = pkg_done;
            r.sleep_a = pkg_done ? value_a : 16'h0000;
            r.sleep_b = pkg_done ? value_b : 16'h0000;
            sleep_q.push_back(r);
            clear_parse();
        end
    endfunction

    function void flag(input string what, input logic [15:0] want, input logic [15:0] got);
        errors++;
        $display("%0t: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
    endfunction

    // compare one accepted result word with the oldest expectation
    function void check_result(input logic f, input logic [15:0] a, input logic [15:0] b);
        result_t want;
        if (sleep_q.size() == 0)
        begin
            errors++;
            $display("%0t: result word expected none, got found=%0b a=0x%0h b=0x%0h",
                     $time, f, a, b);
            return;
        end
        want = sleep_q.pop_front();
        if (f !== want.found)
            flag("found", {15'd0, want.found}, {15'd0, f});
        if (a !== want.sleep_a)
            flag("sleep_type_a", want.sleep_a, a);
        if (b !== want.sleep_b)
            flag("sleep_type_b", want.sleep_b, b);
    endfunction
endclass

module tb_aml_s5_package_scanner_core;

    localparam int STALL_LIMIT = 2000;
    localparam int BODY_BYTES  = 1900;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte    = 8'h00;
    logic        last_byte    = 1'b0;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    logic        found;
    logic [15:0] sleep_type_a;
    logic [15:0] sleep_type_b;

    s5_result_tracker sb;
    logic [7:0]       body_q[$];
    int               bytes_sent   = 0;
    int               stall_cycles = 0;
    bit               send_burst   = 1'b0;
    bit               recv_burst   = 1'b0;

    aml_s5_package_scanner_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .sleep_type_a (sleep_type_a),
        .sleep_type_b (sleep_type_b)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // idle cycles before the next word; burst mode means no idling at all
    function automatic int next_gap(input bit burst);
        return burst ? 0 : $urandom_range(0, 16);
    endfunction

    // random byte, biased toward the characters of the name and the opcode
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 7))
            0:       return CHAR_US;
            1:       return WINDOW_S5[15:8];
            2:       return WINDOW_S5[7:0];
            3:       return PKG_OP;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void push_name();
        body_q.push_back(WINDOW_S5[23:16]);
        body_q.push_back(WINDOW_S5[15:8]);
        body_q.push_back(WINDOW_S5[7:0]);
        body_q.push_back(CHAR_US);
    endfunction

    function automatic void push_element();
        case ($urandom_range(0, 5))
            0: body_q.push_back(OP_ZERO);
            1: body_q.push_back(OP_ONE);
            2:
            begin
                body_q.push_back(OP_BYTE);
                body_q.push_back(8'($urandom));
            end
            3:
            begin
                body_q.push_back(OP_WORD);
                body_q.push_back(8'($urandom));
                body_q.push_back(8'($urandom));
            end
            4: body_q.push_back(OP_ONES);
            default: body_q.push_back(noise_byte());
        endcase
    endfunction

    // one random table: noise, or a package with random contents,
    // sometimes followed by a second package and sometimes cut short
    function automatic void build_random_body();
        int         cut;
        logic [7:0] lead;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 12)) body_q.push_back(noise_byte());
        end
        else
        begin
            repeat ($urandom_range(0, 6)) body_q.push_back(noise_byte());
            push_name();
            body_q.push_back(($urandom_range(0, 9) == 0) ? noise_byte() : PKG_OP);
            lead = 8'($urandom);
            body_q.push_back(lead);
            repeat (lead[7:6]) body_q.push_back(8'($urandom));
            body_q.push_back(8'($urandom));
            push_element();
            push_element();
            if ($urandom_range(0, 7) == 0)
            begin
                push_name();
                body_q.push_back(PKG_OP);
                body_q.push_back(8'h00);
                body_q.push_back(8'h02);
                body_q.push_back(OP_ONE);
                body_q.push_back(OP_ONE);
            end
            repeat ($urandom_range(0, 4)) body_q.push_back(noise_byte());
            if ($urandom_range(0, 5) == 0)
            begin
                cut = $urandom_range(1, body_q.size());
                while (body_q.size() > cut)
                    void'(body_q.pop_back());
            end
        end
    endfunction

    // send the queued table body, last flag on its final word
    task automatic send_body();
        int gap;
        int i;
        for (i = 0; i < body_q.size(); i++)
        begin
            if ($urandom_range(0, 39) == 0)
                send_burst = !send_burst;
            gap = next_gap(send_burst);
            if (gap > 0)
            begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_valid  = 1'b1;
            data_byte = body_q[i];
            last_byte = (i == body_q.size() - 1);
            do @(posedge clk); while (!in_ready);
            @(negedge clk);
            bytes_sent++;
        end
        body_q.delete();
    endtask

    // accepted words on both channels, plus the stall watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_byte(data_byte, last_byte);
            if (out_valid && out_ready)
                sb.check_result(found, sleep_type_a, sleep_type_b);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // result side: random stalls between words
    initial
    begin
        int gap;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                recv_burst = !recv_burst;
            gap = next_gap(recv_burst);
            if (gap > 0)
            begin
                out_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    initial
    begin
        sb = new;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // failed opcode check resumes the search; opcode as final byte
        push_name();
        body_q.push_back(8'h00);
        push_name();
        body_q.push_back(PKG_OP);
        send_body();

        // three extra length bytes, word and byte elements, trailing byte ignored
        push_name();
        body_q.push_back(PKG_OP);
        body_q.push_back(8'hC0);
        body_q.push_back(8'hFF);
        body_q.push_back(8'h00);
        body_q.push_back(8'h80);
        body_q.push_back(8'h02);
        body_q.push_back(OP_WORD);
        body_q.push_back(8'h34);
        body_q.push_back(8'h12);
        body_q.push_back(OP_BYTE);
        body_q.push_back(8'hFE);
        body_q.push_back(OP_ONE);
        send_body();

        // table ends before the second element
        push_name();
        body_q.push_back(PKG_OP);
        body_q.push_back(8'h00);
        body_q.push_back(8'h02);
        body_q.push_back(OP_ONES);
        send_body();

        while (bytes_sent < BODY_BYTES)
        begin
            build_random_body();
            send_body();
        end
        in_valid  = 1'b0;
        last_byte = 1'b0;

        // drain, then allow the result pipeline to settle
        while (sb.sleep_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
